// ===== rtl/selective_repeat_arq_engine_defines.svh =====
// assertion macros for the selective repeat arq engine
`ifndef SELECTIVE_REPEAT_ARQ_ENGINE_DEFINES_SVH
`define SELECTIVE_REPEAT_ARQ_ENGINE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define SRA_ASSERT_IMPL(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("sra assertion failed");

// next-cycle implication, disabled during reset
`define SRA_ASSERT_NEXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("sra assertion failed");

`endif

// ===== rtl/sra_pkg.sv =====
// types, codes and sequence helpers for the selective repeat arq engine
`timescale 1ns / 1ps
`default_nettype none
package sra_pkg;

	localparam int SEQ_MAX = 7;
	localparam int WINDOW  = 4;
	localparam int SEQ_W   = 3;
	localparam int SLOT_W  = 2;
	localparam int OP_W    = 3;
	localparam int KIND_W  = 2;
	localparam int CNT_W   = 3;

	localparam logic [OP_W-1:0] OP_NET_READY = 3'd0;
	localparam logic [OP_W-1:0] OP_PHY_READY = 3'd1;
	localparam logic [OP_W-1:0] OP_FRAME_RX  = 3'd2;
	localparam logic [OP_W-1:0] OP_DATA_TMO  = 3'd3;
	localparam logic [OP_W-1:0] OP_ACK_TMO   = 3'd4;

	localparam logic [KIND_W-1:0] KIND_DATA = 2'd0;
	localparam logic [KIND_W-1:0] KIND_ACK  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_NAK  = 2'd2;

	typedef enum logic [2:0] {
		ACT_STATUS  = 3'd0,
		ACT_DATA    = 3'd1,
		ACT_ACK     = 3'd2,
		ACT_NAK     = 3'd3,
		ACT_STORE   = 3'd4,
		ACT_DELIVER = 3'd5,
		ACT_STOP    = 3'd6,
		ACT_RESTART = 3'd7
	} act_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECODE,
		ST_NET_SEND,
		ST_RESEND,
		ST_ACK,
		ST_BAD_NAK,
		ST_RX_HEAD,
		ST_STORE,
		ST_DELIVER,
		ST_RESTART,
		ST_NAK_CHECK,
		ST_STOP_LOOP,
		ST_STATUS
	} state_t;

	function automatic logic [SEQ_W-1:0] seq_inc(input logic [SEQ_W-1:0] s);
		return (s == SEQ_W'(SEQ_MAX)) ? '0 : s + SEQ_W'(1);
	endfunction

	function automatic logic [SEQ_W-1:0] seq_dec(input logic [SEQ_W-1:0] s);
		return (s == '0) ? SEQ_W'(SEQ_MAX) : s - SEQ_W'(1);
	endfunction

	function automatic logic [SLOT_W-1:0] slot_of(input logic [SEQ_W-1:0] s);
		return SLOT_W'(s % WINDOW);
	endfunction

	// circular a <= b < c
	function automatic logic in_window(input logic [SEQ_W-1:0] a,
		input logic [SEQ_W-1:0] b, input logic [SEQ_W-1:0] c);
		return (a <= b && b < c) || (c < a && a <= b) || (b < c && c < a);
	endfunction

endpackage
`default_nettype wire

// ===== rtl/selective_repeat_arq_engine.sv =====
// selective repeat arq control engine: event sequencer and action output register
// sequencing: an input transfer is captured and decoded, then one action per cycle
//   while taken; scan exits and a skipped nak resend issue no action
// flow: a new event is taken only in idle, after the closing status of the previous run;
//   the sequencer emits one action per cycle through a single output register
// reset: arst_n resets windows, counters, flags and the arrival bitmap at once
`timescale 1ns / 1ps
`default_nettype none
`include "selective_repeat_arq_engine_defines.svh"
module selective_repeat_arq_engine (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	// event channel
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic [sra_pkg::OP_W-1:0]    operation,
	input  wire logic                        frame_good,
	input  wire logic [sra_pkg::KIND_W-1:0]  frame_kind,
	input  wire logic [sra_pkg::SEQ_W-1:0]   rx_seq,
	input  wire logic [sra_pkg::SEQ_W-1:0]   rx_ack,
	input  wire logic [sra_pkg::SEQ_W-1:0]   timeout_seq,
	// action channel
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic [2:0]                       action,
	output logic [sra_pkg::SEQ_W-1:0]        tx_seq,
	output logic [sra_pkg::SEQ_W-1:0]        tx_ack,
	output logic [sra_pkg::SLOT_W-1:0]       buffer_slot,
	output logic                             network_enable,
	output logic                             last
);
	import sra_pkg::*;

	// sequencer state
	state_t state_q, state_d;

	// captured event
	logic [OP_W-1:0]   op_q;
	logic              good_q;
	logic [KIND_W-1:0] kind_q;
	logic [SEQ_W-1:0]  seq_q;
	logic [SEQ_W-1:0]  ack_q;
	logic [SEQ_W-1:0]  tseq_q;

	// protocol state
	logic [SEQ_W-1:0]  swl_q, swl_d;      // send window low edge
	logic [SEQ_W-1:0]  nss_q, nss_d;      // next sequence number to send
	logic [SEQ_W-1:0]  rexp_q, rexp_d;    // receive window low edge
	logic [SEQ_W-1:0]  rfar_q, rfar_d;    // receive window upper edge (exclusive)
	logic [CNT_W-1:0]  outst_q, outst_d;  // frames in flight
	logic              phys_q, phys_d;
	logic              nak_q, nak_d;
	logic [WINDOW-1:0] arrived_q, arrived_d;
	logic              delivered_q, delivered_d;

	// action output register
	logic              out_valid_q;
	act_t              action_q;
	logic [SEQ_W-1:0]  tx_seq_q;
	logic [SEQ_W-1:0]  tx_ack_q;
	logic [SLOT_W-1:0] slot_q;
	logic              en_q;
	logic              last_q;

	// action being issued this cycle
	logic              emit;
	act_t              e_act;
	logic [SEQ_W-1:0]  e_seq;
	logic [SLOT_W-1:0] e_slot;
	logic              e_en;
	logic              e_last;

	logic              can_emit;
	logic              in_xfer;
	logic [SEQ_W-1:0]  ack_next;

	// output register is free when empty or its action transfers now
	assign can_emit = !out_valid_q || out_ready;
	assign in_xfer  = in_valid && in_ready;
	assign ack_next = seq_inc(ack_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			swl_q       <= '0;
			nss_q       <= '0;
			rexp_q      <= '0;
			rfar_q      <= SEQ_W'(WINDOW % (SEQ_MAX + 1));
			outst_q     <= '0;
			phys_q      <= 1'b0;
			nak_q       <= 1'b1;
			arrived_q   <= '0;
			delivered_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			swl_q       <= swl_d;
			nss_q       <= nss_d;
			rexp_q      <= rexp_d;
			rfar_q      <= rfar_d;
			outst_q     <= outst_d;
			phys_q      <= phys_d;
			nak_q       <= nak_d;
			arrived_q   <= arrived_d;
			delivered_q <= delivered_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// event capture and action payload
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			op_q   <= operation;
			good_q <= frame_good;
			kind_q <= frame_kind;
			seq_q  <= rx_seq;
			ack_q  <= rx_ack;
			tseq_q <= timeout_seq;
		end
		if (emit) begin
			action_q <= e_act;
			tx_seq_q <= e_seq;
			tx_ack_q <= seq_dec(rexp_q);   // ack number as it stands at this action
			slot_q   <= e_slot;
			en_q     <= e_en;
			last_q   <= e_last;
		end
	end

	// next state and actions
	always_comb begin
		state_d     = state_q;
		swl_d       = swl_q;
		nss_d       = nss_q;
		rexp_d      = rexp_q;
		rfar_d      = rfar_q;
		outst_d     = outst_q;
		phys_d      = phys_q;
		nak_d       = nak_q;
		arrived_d   = arrived_q;
		delivered_d = delivered_q;
		emit        = 1'b0;
		e_act       = ACT_STATUS;
		e_seq       = '0;
		e_slot      = '0;
		e_en        = 1'b0;
		e_last      = 1'b0;
		in_ready    = 1'b0;

		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = ST_DECODE;
				end
			end
			// pick the action run for this event
			ST_DECODE: begin
				state_d = ST_STATUS;
				unique case (op_q)
					OP_NET_READY: begin
						// full window: status only
						if (outst_q < CNT_W'(WINDOW)) begin
							state_d = ST_NET_SEND;
						end
					end
					OP_PHY_READY: begin
						phys_d = 1'b1;
					end
					OP_FRAME_RX: begin
						if (!good_q) begin
							// damaged frame only ever triggers a nak
							if (nak_q) begin
								state_d = ST_BAD_NAK;
							end
						end else if (kind_q == KIND_DATA) begin
							state_d = ST_RX_HEAD;
						end else begin
							state_d = ST_NAK_CHECK;
						end
					end
					OP_DATA_TMO: begin
						if (in_window(swl_q, tseq_q, nss_q)) begin
							state_d = ST_RESEND;
						end
					end
					OP_ACK_TMO: begin
						state_d = ST_ACK;
					end
					default: begin
					end
				endcase
			end
			// fresh frame from the network layer
			ST_NET_SEND: begin
				if (can_emit) begin
					emit    = 1'b1;
					e_act   = ACT_DATA;
					e_seq   = nss_q;
					e_slot  = slot_of(nss_q);
					outst_d = outst_q + CNT_W'(1);
					phys_d  = 1'b0;
					nss_d   = seq_inc(nss_q);
					state_d = ST_STATUS;
				end
			end
			// retransmit on data timer expiry
			ST_RESEND: begin
				if (can_emit) begin
					emit    = 1'b1;
					e_act   = ACT_DATA;
					e_seq   = tseq_q;
					e_slot  = slot_of(tseq_q);
					phys_d  = 1'b0;
					state_d = ST_STATUS;
				end
			end
			// standalone ack on ack timer expiry
			ST_ACK: begin
				if (can_emit) begin
					emit    = 1'b1;
					e_act   = ACT_ACK;
					e_seq   = nss_q;
					phys_d  = 1'b0;
					state_d = ST_STATUS;
				end
			end
			ST_BAD_NAK: begin
				if (can_emit) begin
					emit    = 1'b1;
					e_act   = ACT_NAK;
					nak_d   = 1'b0;
					phys_d  = 1'b0;
					state_d = ST_STATUS;
				end
			end
			// data frame: nak on a gap while a nak is allowed, else restart the ack timer
			ST_RX_HEAD: begin
				if (can_emit) begin
					emit = 1'b1;
					if (seq_q != rexp_q && nak_q) begin
						e_act  = ACT_NAK;
						nak_d  = 1'b0;
						phys_d = 1'b0;
					end else begin
						e_act = ACT_RESTART;
					end
					if (in_window(rexp_q, seq_q, rfar_q) && !arrived_q[slot_of(seq_q)]) begin
						state_d = ST_STORE;
					end else begin
						state_d = ST_STOP_LOOP;
					end
				end
			end
			ST_STORE: begin
				if (can_emit) begin
					emit                       = 1'b1;
					e_act                      = ACT_STORE;
					e_seq                      = seq_q;
					e_slot                     = slot_of(seq_q);
					arrived_d[slot_of(seq_q)]  = 1'b1;
					delivered_d                = 1'b0;
					state_d                    = ST_DELIVER;
				end
			end
			// hand up frames in order while the head of the window has arrived
			ST_DELIVER: begin
				if (arrived_q[slot_of(rexp_q)]) begin
					if (can_emit) begin
						emit                       = 1'b1;
						e_act                      = ACT_DELIVER;
						e_seq                      = rexp_q;
						e_slot                     = slot_of(rexp_q);
						nak_d                      = 1'b1;
						arrived_d[slot_of(rexp_q)] = 1'b0;
						rexp_d                     = seq_inc(rexp_q);
						rfar_d                     = seq_inc(rfar_q);
						delivered_d                = 1'b1;
					end
				end else if (delivered_q) begin
					state_d = ST_RESTART;
				end else begin
					state_d = ST_STOP_LOOP;
				end
			end
			ST_RESTART: begin
				if (can_emit) begin
					emit    = 1'b1;
					e_act   = ACT_RESTART;
					state_d = ST_STOP_LOOP;
				end
			end
			// nak frame: resend the frame after the acked one if still in flight
			ST_NAK_CHECK: begin
				if (kind_q == KIND_NAK && in_window(swl_q, ack_next, nss_q)) begin
					if (can_emit) begin
						emit    = 1'b1;
						e_act   = ACT_DATA;
						e_seq   = ack_next;
						e_slot  = slot_of(ack_next);
						phys_d  = 1'b0;
						state_d = ST_STOP_LOOP;
					end
				end else begin
					state_d = ST_STOP_LOOP;
				end
			end
			// cumulative ack: retire frames up to and including ack
			ST_STOP_LOOP: begin
				if (in_window(swl_q, ack_q, nss_q)) begin
					if (can_emit) begin
						emit   = 1'b1;
						e_act  = ACT_STOP;
						e_seq  = swl_q;
						e_slot = slot_of(swl_q);
						if (outst_q != '0) begin
							outst_d = outst_q - CNT_W'(1);
						end
						swl_d = seq_inc(swl_q);
					end
				end else begin
					state_d = ST_STATUS;
				end
			end
			// closing status of every run
			ST_STATUS: begin
				if (can_emit) begin
					emit    = 1'b1;
					e_act   = ACT_STATUS;
					e_en    = (outst_q < CNT_W'(WINDOW)) && phys_q;
					e_last  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign out_valid      = out_valid_q;
	assign action         = action_q;
	assign tx_seq         = tx_seq_q;
	assign tx_ack         = tx_ack_q;
	assign buffer_slot    = slot_q;
	assign network_enable = en_q;
	assign last           = last_q;

	// in-flight count never exceeds the window
	`SRA_ASSERT_IMPL(a_outst_bound, 1'b1, outst_q <= CNT_W'(WINDOW))
	// only the status action closes a run
	`SRA_ASSERT_IMPL(a_last_status, out_valid_q && last_q, action_q == ACT_STATUS)
	// between events the only pending action is the closing status
	`SRA_ASSERT_IMPL(a_idle_pending, state_q == ST_IDLE && out_valid_q, last_q)
	// head of the receive window is never left marked as arrived between events
	`SRA_ASSERT_IMPL(a_head_clear, state_q == ST_IDLE, !arrived_q[slot_of(rexp_q)])
	// an accepted event always opens with a decode cycle
	`SRA_ASSERT_NEXT(a_decode_next, in_xfer, state_q == ST_DECODE)

endmodule
`default_nettype wire
